### sv/integer_set_table_defines.svh
// Assertion macros shared by the integer set table RTL.
// Included by the top level, which carries the concurrent checks; no other dependencies.
`ifndef INTEGER_SET_TABLE_DEFINES_SVH
`define INTEGER_SET_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define IST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: check failed");

// expr must never be true outside reset
`define IST_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define IST_ASSERT(lbl, clk, rstn, prop)
`define IST_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

### sv/ist_pkg.sv
// Shared types and constants for the integer set table.
// No dependencies; used by the interfaces, the cell and the top level.
package ist_pkg;

  localparam int SET_DEPTH = 16;
  localparam int VALUE_W   = 32;
  localparam int OPCODE_W  = 2;
  localparam int COUNT_W   = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic {
    PH_SEARCH = 1'b0,
    PH_COMMIT = 1'b1
  } phase_e;

  // request token walking the cell row
  typedef struct packed {
    phase_e                     phase;
    logic [OPCODE_W-1:0]        op;
    logic signed [VALUE_W-1:0]  value;
    logic                       found;
    logic                       placed;
  } token_t;

endpackage

### sv/ist_req_if.sv
// Request channel of the integer set table: valid/ready plus opcode and value.
// Depends on ist_pkg for field widths.
interface ist_req_if;
  logic                                      valid;
  logic                                      ready;
  logic [ist_pkg::OPCODE_W-1:0]              opcode;
  logic signed [ist_pkg::VALUE_W-1:0]        value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

### sv/ist_rsp_if.sv
// Response channel of the integer set table: valid/ready plus result flags and count.
// Depends on ist_pkg for field widths.
interface ist_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          was_present;
  logic                          add_refused;
  logic [ist_pkg::COUNT_W-1:0]   element_count;

  modport source (output valid, output was_present, output add_refused,
                  output element_count, input ready);
  modport sink   (input valid, input was_present, input add_refused,
                  input element_count, output ready);
endinterface

### sv/ist_cell.sv
// One slot of the set: value, valid bit and one register stage of the token row.
// Depends on ist_pkg for the token type and opcodes.
module ist_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_vld_i,
  input  ist_pkg::token_t tok_i,
  output logic            tok_vld_o,
  output ist_pkg::token_t tok_o
);

  logic                               valid_q, valid_d;
  logic signed [ist_pkg::VALUE_W-1:0] value_q;
  logic                               wr_en;
  logic                               hit;
  logic                               tok_vld_q;
  ist_pkg::token_t                    tok_q, tok_d;

  assign hit = valid_q && (value_q == tok_i.value);

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    wr_en   = 1'b0;
    if (tok_vld_i) begin
      case (tok_i.phase)
        ist_pkg::PH_SEARCH: begin
          tok_d.found = tok_i.found | hit;
        end
        ist_pkg::PH_COMMIT: begin
          case (tok_i.op)
            ist_pkg::OP_ADD: begin
              // lowest free slot takes the value
              if (!tok_i.found && !tok_i.placed && !valid_q) begin
                wr_en        = 1'b1;
                valid_d      = 1'b1;
                tok_d.placed = 1'b1;
              end
            end
            ist_pkg::OP_REMOVE: begin
              if (hit) begin
                valid_d = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      value_q <= tok_i.value;
    end
    if (tok_vld_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule

### sv/integer_set_table.sv
// Integer set table: a fixed-capacity set of distinct 32-bit signed integers.
// Depends on ist_pkg, ist_req_if, ist_rsp_if, ist_cell and the defines header.
//
// Usage:
//   req_i carries opcode (add, remove, query; code 3 acts as query) and value.
//   rsp_o returns one word per request: was_present, add_refused and the
//   element count after the request (low 5 bits).
//   Storage is a row of SET_DEPTH cells. A request becomes a token that walks
//   the row one cell per cycle twice: a search pass that collects the match,
//   then a commit pass that fills the lowest free slot (add) or clears the match (remove).
//   One request is in flight at a time; req_i.ready rises again in the cycle
//   in which its result appears on rsp_o, so the block takes no new request
//   before the result of the last one has reached rsp_o.
//   A finished result that finds the output register still occupied parks in
//   a holding register; req_i.ready stays low until the receiver takes a word
//   and the held result moves up to rsp_o.
//   Reset empties the set and both result registers; slot and result contents
//   are not cleared, only their valid bits.
`include "integer_set_table_defines.svh"

module integer_set_table #(
  parameter int SET_DEPTH = ist_pkg::SET_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  ist_req_if.sink   req_i,
  ist_rsp_if.source rsp_o
);

  localparam int CNT_W = $clog2(SET_DEPTH + 1);

  logic                 tok_vld [SET_DEPTH+1];
  ist_pkg::token_t      tok     [SET_DEPTH+1];
  logic                 head_vld;
  ist_pkg::token_t      head_tok;
  logic [SET_DEPTH-1:0] vld_vec;

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             in_fire, wrap, done, out_free;
  logic             added, removed;
  logic             res_present, res_refused;
  logic [31:0]      cnt_ext;

  logic                         out_vld_q, out_vld_d;
  logic                         out_present_q, out_refused_q;
  logic [ist_pkg::COUNT_W-1:0]  out_count_q;
  logic                         pend_vld_q, pend_vld_d;
  logic                         pend_present_q, pend_refused_q;
  logic [ist_pkg::COUNT_W-1:0]  pend_count_q;
  logic                         load_out_res, load_out_pend, load_pend;

  assign req_i.ready = !busy_q;
  assign in_fire     = req_i.valid && !busy_q;

  assign wrap = tok_vld[SET_DEPTH] && (tok[SET_DEPTH].phase == ist_pkg::PH_SEARCH);
  assign done = tok_vld[SET_DEPTH] && (tok[SET_DEPTH].phase == ist_pkg::PH_COMMIT);

  // head of the row: new request, or the search token coming back to commit
  always_comb begin
    head_vld = in_fire || wrap;
    head_tok = tok[SET_DEPTH];
    if (in_fire) begin
      head_tok.phase  = ist_pkg::PH_SEARCH;
      head_tok.op     = req_i.opcode;
      head_tok.value  = req_i.value;
      head_tok.found  = 1'b0;
      head_tok.placed = 1'b0;
    end else begin
      head_tok.phase  = ist_pkg::PH_COMMIT;
      head_tok.placed = 1'b0;
    end
  end

  assign tok_vld[0] = head_vld;
  assign tok[0]     = head_tok;

  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    ist_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_vld_i (tok_vld[i]),
      .tok_i     (tok[i]),
      .tok_vld_o (tok_vld[i+1]),
      .tok_o     (tok[i+1])
    );
    assign vld_vec[i] = tok_vld[i+1];
  end

  // result of the finished commit pass
  always_comb begin
    added       = tok[SET_DEPTH].placed;
    removed     = (tok[SET_DEPTH].op == ist_pkg::OP_REMOVE) && tok[SET_DEPTH].found;
    res_present = tok[SET_DEPTH].found;
    res_refused = (tok[SET_DEPTH].op == ist_pkg::OP_ADD) && !tok[SET_DEPTH].found
                  && !tok[SET_DEPTH].placed;
    count_d = count_q;
    if (done) begin
      if (added) begin
        count_d = count_q + CNT_W'(1);
      end else if (removed) begin
        count_d = count_q - CNT_W'(1);
      end
    end
    cnt_ext = 32'(count_d);
  end

  assign out_free      = !out_vld_q || rsp_o.ready;
  assign load_out_res  = done && out_free;
  assign load_pend     = done && !out_free;
  assign load_out_pend = pend_vld_q && rsp_o.ready;

  always_comb begin
    out_vld_d  = out_vld_q;
    pend_vld_d = pend_vld_q;
    busy_d     = busy_q;
    if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (load_out_res || load_out_pend) begin
      out_vld_d = 1'b1;
      busy_d    = 1'b0;
    end
    if (load_out_pend) begin
      pend_vld_d = 1'b0;
    end
    if (load_pend) begin
      pend_vld_d = 1'b1;
    end
    if (in_fire) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      count_q    <= '0;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      count_q    <= count_d;
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_res) begin
      out_present_q <= res_present;
      out_refused_q <= res_refused;
      out_count_q   <= cnt_ext[ist_pkg::COUNT_W-1:0];
    end else if (load_out_pend) begin
      out_present_q <= pend_present_q;
      out_refused_q <= pend_refused_q;
      out_count_q   <= pend_count_q;
    end
    if (load_pend) begin
      pend_present_q <= res_present;
      pend_refused_q <= res_refused;
      pend_count_q   <= cnt_ext[ist_pkg::COUNT_W-1:0];
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.was_present   = out_present_q;
  assign rsp_o.add_refused   = out_refused_q;
  assign rsp_o.element_count = out_count_q;

  // at most one token in the row
  `IST_ASSERT(a_one_token, clk_i, rst_ni, $onehot0(vld_vec))
  // a new request never enters while a token is still walking
  `IST_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, in_fire && (vld_vec != '0))
  // a finished pass always belongs to an accepted request
  `IST_ASSERT(a_done_busy, clk_i, rst_ni, done |-> busy_q)
  // element count never exceeds the number of slots
  `IST_ASSERT(a_count_range, clk_i, rst_ni, 32'(count_q) <= 32'(SET_DEPTH))
  // holding register only fills when the output register is still occupied
  `IST_ASSERT(a_pend_needs_out, clk_i, rst_ni, pend_vld_q |-> out_vld_q)

endmodule

### sim/integer_set_table_checker.sv
// Checker for the integer set table: watches the request and response words,
// keeps its own copy of the set and compares every response in order.
// Depends on ist_pkg, ist_req_if and ist_rsp_if.
module integer_set_table_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ist_req_if   req_mon,
  ist_rsp_if   rsp_mon,
  output int   mismatch_count_o,
  output int   outstanding_o,
  output int   checked_o,
  output int   refused_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        was_present;
    logic                        add_refused;
    logic [ist_pkg::COUNT_W-1:0] element_count;
  } set_result_t;

  logic [ist_pkg::VALUE_W-1:0] slot_value [ist_pkg::SET_DEPTH];
  logic                        slot_used  [ist_pkg::SET_DEPTH];
  int unsigned                 member_total;

  set_result_t expected_results [$];
  int          mismatches;
  int          checked;
  int          refused;

  // Applies one request to the shadow set and returns the response it should get.
  function automatic set_result_t apply_request(logic [ist_pkg::OPCODE_W-1:0] op,
                                                logic [ist_pkg::VALUE_W-1:0] value);
    set_result_t res;
    int          hit;
    int          free;
    hit  = -1;
    free = -1;
    for (int i = 0; i < ist_pkg::SET_DEPTH; i++) begin
      if (slot_used[i] && slot_value[i] == value && hit < 0) hit = i;
      if (!slot_used[i] && free < 0) free = i;
    end
    res.was_present = (hit >= 0);
    res.add_refused = 1'b0;
    case (op)
      ist_pkg::OP_ADD: begin
        if (hit < 0) begin
          if (free >= 0) begin
            slot_value[free] = value;
            slot_used[free]  = 1'b1;
            member_total++;
          end else begin
            res.add_refused = 1'b1;
          end
        end
      end
      ist_pkg::OP_REMOVE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          member_total--;
        end
      end
      default: ;  // query and the unused code leave the set alone
    endcase
    res.element_count = member_total[ist_pkg::COUNT_W-1:0];
    return res;
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    set_result_t want;
    set_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < ist_pkg::SET_DEPTH; i++) begin
        slot_used[i]  = 1'b0;
        slot_value[i] = '0;
      end
      member_total = 0;
      expected_results.delete();
      mismatches = 0;
      checked    = 0;
      refused    = 0;
    end else begin
      // response side first: a word leaving now can never belong to a request
      // accepted at the same edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.was_present   = rsp_mon.was_present;
        got.add_refused   = rsp_mon.add_refused;
        got.element_count = rsp_mon.element_count;
        if (expected_results.size() == 0) begin
          note_failure($sformatf({"%0t: response word with nothing pending: ",
                                  "present=%0b refused=%0b count=%0d"},
                                 $realtime, got.was_present, got.add_refused,
                                 got.element_count));
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.add_refused) refused++;
          if (got.was_present !== want.was_present ||
              got.add_refused !== want.add_refused ||
              got.element_count !== want.element_count) begin
            note_failure($sformatf({"%0t: mismatch: expected present=%0b refused=%0b ",
                                    "count=%0d, got present=%0b refused=%0b count=%0d"},
                                   $realtime, want.was_present, want.add_refused,
                                   want.element_count, got.was_present,
                                   got.add_refused, got.element_count));
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_results.push_back(apply_request(req_mon.opcode, req_mon.value));
      end
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= expected_results.size();
    checked_o        <= checked;
    refused_o        <= refused;
  end

endmodule

### sim/integer_set_table_tb.sv
// Top of the integer set table testbench: clock, reset, request and response
// drivers, watchdog and verdict. Depends on ist_pkg, the interfaces, the block
// and integer_set_table_checker.
module integer_set_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ist_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 1125;
  localparam int POOL_SIZE     = 20;
  localparam int IDLE_LIMIT    = 1000;
  localparam int DRAIN_CYCLES  = 2 * ist_pkg::SET_DEPTH + 10;

  logic clk_i;
  logic rst_ni;

  ist_req_if req_if ();
  ist_rsp_if rsp_if ();

  int mismatch_count;
  int outstanding;
  int checked;
  int refused;

  integer_set_table u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  integer_set_table_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_mon          (req_if),
    .rsp_mon          (rsp_if),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding),
    .checked_o        (checked),
    .refused_o        (refused)
  );

  logic [ist_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];
  logic [ist_pkg::VALUE_W-1:0] loose_values [$];  // added values outside the pool
  bit                          no_idle;
  int                          sent;
  int                          directed;
  int                          idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    req_if.valid  = 1'b0;
    req_if.opcode = ist_pkg::OP_QUERY;
    req_if.value  = '0;
    rsp_if.ready  = 1'b0;
  end

  // Sends one request word: random gap with valid low, then hold until taken.
  task automatic send(logic [ist_pkg::OPCODE_W-1:0] op, logic [ist_pkg::VALUE_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid  = 1'b1;
    req_if.opcode = op;
    req_if.value  = v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  function automatic logic [ist_pkg::VALUE_W-1:0] pick_value(
      logic [ist_pkg::OPCODE_W-1:0] op);
    logic [ist_pkg::VALUE_W-1:0] v;
    int                          idx;
    if (op == ist_pkg::OP_REMOVE && loose_values.size() > 0 &&
        $urandom_range(0, 4) == 0) begin
      idx = $urandom_range(0, loose_values.size() - 1);
      v   = loose_values[idx];
      loose_values.delete(idx);
    end else if ($urandom_range(0, 99) < 12) begin
      v = $urandom;
      if (op == ist_pkg::OP_ADD && loose_values.size() < 16) loose_values.push_back(v);
    end else begin
      v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return v;
  endfunction

  // Response side: random stall before each word, sometimes none at all.
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no word accepted for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [ist_pkg::OPCODE_W-1:0] op;
    int                           r;
    bit                           grow;
    sent        = 0;
    no_idle     = 1'b0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    value_pool[5] = 32'h5555_5555;
    value_pool[6] = 32'haaaa_aaaa;
    for (int i = 7; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty set, extremes, duplicates, absent removes, fill to full
    send(ist_pkg::OP_QUERY,  32'h0000_0000);
    send(ist_pkg::OP_REMOVE, 32'h0000_0000);
    send(ist_pkg::OP_ADD,    32'h8000_0000);
    send(ist_pkg::OP_ADD,    32'h7fff_ffff);
    send(ist_pkg::OP_ADD,    32'h0000_0000);
    send(ist_pkg::OP_ADD,    32'hffff_ffff);
    send(ist_pkg::OP_ADD,    32'h7fff_ffff);
    send(OP_UNUSED,          32'hffff_ffff);
    send(ist_pkg::OP_QUERY,  32'h1234_5678);
    send(ist_pkg::OP_REMOVE, 32'h0000_0000);
    send(ist_pkg::OP_REMOVE, 32'h0000_0000);
    send(ist_pkg::OP_ADD,    32'h0000_0000);  // reuses the slot just freed
    for (int i = 0; i < ist_pkg::SET_DEPTH - 4; i++) begin
      loose_values.push_back((i % 2) ? (32'h5555_5550 | i) : (32'haaaa_aaa0 | i));
      send(ist_pkg::OP_ADD, loose_values[$]);
    end
    send(ist_pkg::OP_ADD,    32'h0000_0001);  // absent value, table full
    send(ist_pkg::OP_ADD,    32'h8000_0000);  // present value, table full
    send(ist_pkg::OP_QUERY,  32'h7fff_ffff);
    directed = sent;

    // random: alternating grow and shrink stretches over a shared value pool
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        grow    = ((n / 100) % 2 == 0);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (grow) begin
        op = (r < 60) ? ist_pkg::OP_ADD : (r < 85) ? ist_pkg::OP_REMOVE :
             (r < 97) ? ist_pkg::OP_QUERY : OP_UNUSED;
      end else begin
        op = (r < 25) ? ist_pkg::OP_ADD : (r < 75) ? ist_pkg::OP_REMOVE :
             (r < 95) ? ist_pkg::OP_QUERY : OP_UNUSED;
      end
      send(op, pick_value(op));
    end
    req_if.valid = 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests sent (%0d directed, the rest random over add, remove, query",
             sent, directed);
    $display("and the unused code); %0d responses checked, %0d adds refused on a full set",
             checked, refused);
    if (outstanding != 0) $display("%0d responses never arrived", outstanding);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
